// ----- rtl/linear_reservoir_runoff_routing_unit_assert.svh -----
// Assertion macros shared by the linear reservoir routing unit.
// Included by the RTL files that carry checks; no other dependencies.
`ifndef LINEAR_RESERVOIR_RUNOFF_ROUTING_UNIT_ASSERT_SVH
`define LINEAR_RESERVOIR_RUNOFF_ROUTING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linear reservoir routing check failed");
// Antecedent implies consequent in the next cycle.
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linear reservoir routing check failed");
`else
`define LRR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/lrr_pkg.sv -----
// Package of the linear reservoir routing unit: widths, register indexes,
// payload and control structs. Used by every RTL module; depends on nothing.
package lrr_pkg;

    // Field and datapath widths.
    localparam int FLOW_WIDTH       = 40;
    localparam int COEF_FRAC_BITS   = 16;
    localparam int DEPTH_W          = 20;
    localparam int COEF_REG_W       = 17;
    localparam int FACTOR_W         = 32;
    localparam int FACTOR_FRAC_BITS = 16;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int MUL_W            = 32;

    // A flow is fed to the multiplier in chunks of MUL_W bits.
    localparam int NUM_CHUNKS  = (FLOW_WIDTH + MUL_W - 1) / MUL_W;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_COEF   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTERFLOW_COEF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_COEF    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COEF   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_IMPERV_FRAC    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_FACTOR    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ROUTE  = CFG_IDX_W'(6);

    // One input item: runoff depths of one time step.
    typedef struct packed {
        logic [DEPTH_W-1:0] surface_depth;
        logic [DEPTH_W-1:0] interflow_depth;
        logic [DEPTH_W-1:0] ground_depth;
        logic [DEPTH_W-1:0] imperv_depth;
    } t_in_item;

    // One result item: reservoir outflows and outlet flow.
    typedef struct packed {
        logic [FLOW_WIDTH-1:0] surface_flow;
        logic [FLOW_WIDTH-1:0] interflow_flow;
        logic [FLOW_WIDTH-1:0] ground_flow;
        logic [FLOW_WIDTH-1:0] total_flow;
        logic [FLOW_WIDTH-1:0] unit_outflow;
    } t_out_item;

    // Configuration register contents as written.
    typedef struct packed {
        logic [COEF_REG_W-1:0] surface_coef;
        logic [COEF_REG_W-1:0] interflow_coef;
        logic [COEF_REG_W-1:0] ground_coef;
        logic [COEF_REG_W-1:0] channel_coef;
        logic [COEF_REG_W-1:0] imperv_frac;
        logic [FACTOR_W-1:0]   unit_factor;
        logic                  channel_route_en;
    } t_cfg;

    // One operation for the shared multiply-accumulate unit.
    typedef struct packed {
        logic                   vld;
        logic                   clr;
        logic                   rnd;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic [MUL_W-1:0]       a;
        logic [MUL_W-1:0]       b;
    } t_mac_op;

    // Accumulator width: reservoir sums, depth-to-flow products and the
    // saturation test on the flow conversion all have to fit.
    function automatic int acc_width(input int cfb);
        int w;
        w = FLOW_WIDTH + cfb + 1;
        if (FLOW_WIDTH + FACTOR_FRAC_BITS + 1 > w) begin
            w = FLOW_WIDTH + FACTOR_FRAC_BITS + 1;
        end
        if (2 * MUL_W > w) begin
            w = 2 * MUL_W;
        end
        return w;
    endfunction

endpackage

// ----- rtl/lrr_cfg.sv -----
// Configuration register file of the linear reservoir routing unit.
// Depends on lrr_pkg for the register indexes and the t_cfg struct.
module lrr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lrr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lrr_pkg::t_cfg                    o_cfg
);

    lrr_pkg::t_cfg r_cfg;

    // Register writes; data is cut to each register's width and an
    // unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lrr_pkg::CFG_SURFACE_COEF: begin
                    r_cfg.surface_coef <= i_cfg_data[lrr_pkg::COEF_REG_W-1:0];
                end
                lrr_pkg::CFG_INTERFLOW_COEF: begin
                    r_cfg.interflow_coef <= i_cfg_data[lrr_pkg::COEF_REG_W-1:0];
                end
                lrr_pkg::CFG_GROUND_COEF: begin
                    r_cfg.ground_coef <= i_cfg_data[lrr_pkg::COEF_REG_W-1:0];
                end
                lrr_pkg::CFG_CHANNEL_COEF: begin
                    r_cfg.channel_coef <= i_cfg_data[lrr_pkg::COEF_REG_W-1:0];
                end
                lrr_pkg::CFG_IMPERV_FRAC: begin
                    r_cfg.imperv_frac <= i_cfg_data[lrr_pkg::COEF_REG_W-1:0];
                end
                lrr_pkg::CFG_UNIT_FACTOR: begin
                    r_cfg.unit_factor <= i_cfg_data[lrr_pkg::FACTOR_W-1:0];
                end
                lrr_pkg::CFG_CHANNEL_ROUTE: begin
                    r_cfg.channel_route_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/lrr_mac.sv -----
// Shared multiply-accumulate unit: one registered 32x32 product per cycle,
// added at a chunk offset into a wide accumulator. Depends on lrr_pkg.
module lrr_mac #(
    parameter int COEF_FRAC_BITS = lrr_pkg::COEF_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  lrr_pkg::t_mac_op                              i_op,
    output logic [lrr_pkg::acc_width(COEF_FRAC_BITS)-1:0] o_acc
);

    localparam int ACC_W = lrr_pkg::acc_width(COEF_FRAC_BITS);
    localparam int PROD_W = 2 * lrr_pkg::MUL_W;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic                               r_vld;
    logic                               r_clr;
    logic                               r_rnd;
    logic [lrr_pkg::CHUNK_IDX_W-1:0]    r_chunk;
    logic [PROD_W-1:0]                  r_prod;
    logic [ACC_W-1:0]                   r_acc;
    logic [ACC_W-1:0]                   acc_base;
    logic [ACC_W-1:0]                   prod_shifted;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.vld;
        end
        r_clr   <= i_op.clr;
        r_rnd   <= i_op.rnd;
        r_chunk <= i_op.chunk;
        r_prod  <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
    end

    // A cleared sum starts from the rounding half or from zero.
    assign acc_base     = r_clr ? (r_rnd ? HALF : '0) : r_acc;
    assign prod_shifted = ACC_W'(r_prod) << (r_chunk * lrr_pkg::MUL_W);

    // Accumulate stage.
    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc <= acc_base + prod_shifted;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/lrr_ctrl.sv -----
// Sequencer and datapath registers of the linear reservoir routing unit:
// steps each item through the shared MAC and holds the reservoir stores.
// Depends on lrr_pkg and the assertion macro header.
`include "linear_reservoir_runoff_routing_unit_assert.svh"

module lrr_ctrl #(
    parameter int COEF_FRAC_BITS = lrr_pkg::COEF_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  lrr_pkg::t_cfg                                 i_cfg,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  lrr_pkg::t_in_item                             i_in_data,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output lrr_pkg::t_out_item                            o_out_data,
    output lrr_pkg::t_mac_op                              o_op,
    input  logic [lrr_pkg::acc_width(COEF_FRAC_BITS)-1:0] i_acc
);

    localparam int FW    = lrr_pkg::FLOW_WIDTH;
    localparam int CW    = COEF_FRAC_BITS + 1;
    localparam int ACC_W = lrr_pkg::acc_width(COEF_FRAC_BITS);
    localparam int NCH   = lrr_pkg::NUM_CHUNKS;
    localparam int CH_W  = lrr_pkg::CHUNK_IDX_W;
    localparam int M_W   = $clog2(2 * NCH);
    localparam int MW    = lrr_pkg::MUL_W;
    localparam int DW    = lrr_pkg::DEPTH_W;
    localparam int CMP_W = (lrr_pkg::COEF_REG_W > CW) ? lrr_pkg::COEF_REG_W : CW;
    localparam int FFB   = lrr_pkg::FACTOR_FRAC_BITS;

    localparam logic [CW-1:0]  ONE    = {1'b1, {COEF_FRAC_BITS{1'b0}}};
    localparam logic [M_W-1:0] M_LAST = M_W'(2 * NCH - 1);
    localparam logic [M_W-1:0] M_NCH  = M_W'(NCH);

    // Reservoir indexes.
    localparam logic [1:0] RES_SURFACE = 2'd0;
    localparam logic [1:0] RES_INTER   = 2'd1;
    localparam logic [1:0] RES_GROUND  = 2'd2;
    localparam logic [1:0] RES_CHANNEL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_PERV, S_PWAIT, S_FLOW, S_FWAIT, S_XCAP,
        S_RMAC, S_RWAIT, S_RDONE, S_SUM1, S_SUM2, S_DONE
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_res;
    logic [M_W-1:0]         r_m;
    lrr_pkg::t_in_item      r_in;
    logic [FW-1:0]          r_x;
    logic [FW-1:0]          r_tot;
    logic [FW-1:0]          r_store [0:3];
    lrr_pkg::t_out_item     r_out;
    logic                   r_out_vld;
    logic                   n_out_vld;

    logic [DW-1:0]          depth_sel;
    logic [lrr_pkg::COEF_REG_W-1:0] coef_raw;
    logic [CW-1:0]          coef;
    logic [CW-1:0]          kcoef;
    logic [CW-1:0]          perv;
    logic [DW:0]            perv_depth;
    logic [FW-1:0]          flow_sat;
    logic [FW-1:0]          res_new;
    logic                   in_q;
    logic [M_W-1:0]         chunk_full;
    logic [CH_W-1:0]        chunk;
    logic [NCH*MW-1:0]      q_pad;
    logic [NCH*MW-1:0]      x_pad;
    logic [FW-1:0]          sum_a;
    logic [FW-1:0]          sum_b;
    logic [FW:0]            sum_raw;
    logic [FW-1:0]          sum_sat;
    logic [FW-1:0]          unit_flow;
    logic                   out_load;
    lrr_pkg::t_mac_op       op;

    // A coefficient or fraction above one counts as one.
    function automatic logic [CW-1:0] clamp_one(input logic [lrr_pkg::COEF_REG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve > CMP_W'(ONE)) begin
            ve = CMP_W'(ONE);
        end
        return CW'(ve);
    endfunction

    // Depth and coefficient of the reservoir being worked on.
    always_comb begin
        unique case (r_res)
            RES_SURFACE: depth_sel = r_in.surface_depth;
            RES_INTER:   depth_sel = r_in.interflow_depth;
            default:     depth_sel = r_in.ground_depth;
        endcase
    end

    always_comb begin
        unique case (r_res)
            RES_SURFACE: coef_raw = i_cfg.surface_coef;
            RES_INTER:   coef_raw = i_cfg.interflow_coef;
            RES_GROUND:  coef_raw = i_cfg.ground_coef;
            default:     coef_raw = i_cfg.channel_coef;
        endcase
    end

    assign coef  = clamp_one(coef_raw);
    assign kcoef = ONE - coef;
    assign perv  = ONE - clamp_one(i_cfg.imperv_frac);

    // Rounded pervious depth; the impervious depth joins the surface one.
    assign perv_depth = (DW + 1)'(i_acc[COEF_FRAC_BITS +: DW])
                      + ((r_res == RES_SURFACE) ? (DW + 1)'(r_in.imperv_depth) : '0);

    // Depth-to-flow product, truncated and saturated.
    assign flow_sat = (|i_acc[ACC_W-1:FW+FFB]) ? {FW{1'b1}} : i_acc[FFB +: FW];

    // New reservoir outflow from the rounded weighted sum.
    assign res_new = i_acc[COEF_FRAC_BITS +: FW];

    // Chunk selection for the reservoir sum: store chunks, then inflow chunks.
    assign in_q       = (r_m < M_NCH);
    assign chunk_full = in_q ? r_m : (r_m - M_NCH);
    assign chunk      = CH_W'(chunk_full);
    assign q_pad      = (NCH * MW)'(r_store[r_res]);
    assign x_pad      = (NCH * MW)'(r_x);

    // Shared saturating adder for the total flow.
    assign sum_a   = (r_state == S_SUM1) ? r_store[RES_SURFACE] : r_tot;
    assign sum_b   = (r_state == S_SUM1) ? r_store[RES_INTER] : r_store[RES_GROUND];
    assign sum_raw = {1'b0, sum_a} + {1'b0, sum_b};
    assign sum_sat = sum_raw[FW] ? {FW{1'b1}} : sum_raw[FW-1:0];

    assign unit_flow = i_cfg.channel_route_en ? r_store[RES_CHANNEL] : r_tot;

    // The output register loads once the previous result has been taken, and
    // otherwise stays full until its transfer.
    assign out_load  = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign n_out_vld = out_load || (r_out_vld && i_out_stall);

    // Operation issued to the MAC in each state.
    always_comb begin
        op = '0;
        unique case (r_state)
            S_PERV: begin
                op.vld = 1'b1;
                op.clr = 1'b1;
                op.rnd = 1'b1;
                op.a   = MW'(depth_sel);
                op.b   = MW'(perv);
            end
            S_FLOW: begin
                op.vld = 1'b1;
                op.clr = 1'b1;
                op.a   = MW'(perv_depth);
                op.b   = i_cfg.unit_factor;
            end
            S_RMAC: begin
                op.vld   = 1'b1;
                op.clr   = (r_m == '0);
                op.rnd   = (r_m == '0);
                op.chunk = chunk;
                op.a     = in_q ? q_pad[chunk*MW +: MW] : x_pad[chunk*MW +: MW];
                op.b     = in_q ? MW'(coef) : MW'(kcoef);
            end
            default: begin
            end
        endcase
    end

    // Sequencer, stores and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res     <= RES_SURFACE;
            r_m       <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_out_vld <= n_out_vld;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_res   <= RES_SURFACE;
                        r_state <= S_PERV;
                    end
                end
                S_PERV:  r_state <= S_PWAIT;
                S_PWAIT: r_state <= S_FLOW;
                S_FLOW:  r_state <= S_FWAIT;
                S_FWAIT: r_state <= S_XCAP;
                S_XCAP: begin
                    r_x     <= flow_sat;
                    r_m     <= '0;
                    r_state <= S_RMAC;
                end
                S_RMAC: begin
                    if (r_m == M_LAST) begin
                        r_state <= S_RWAIT;
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                end
                S_RWAIT: r_state <= S_RDONE;
                S_RDONE: begin
                    r_store[r_res] <= res_new;
                    if (r_res == RES_GROUND) begin
                        r_state <= S_SUM1;
                    end else if (r_res == RES_CHANNEL) begin
                        r_state <= S_DONE;
                    end else begin
                        r_res   <= r_res + 1'b1;
                        r_state <= S_PERV;
                    end
                end
                S_SUM1: begin
                    r_tot   <= sum_sat;
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_tot <= sum_sat;
                    r_x   <= sum_sat;
                    if (i_cfg.channel_route_en) begin
                        r_res   <= RES_CHANNEL;
                        r_m     <= '0;
                        r_state <= S_RMAC;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Wait here only while the previous result is still unclaimed.
                    if (out_load) begin
                        r_out.surface_flow   <= r_store[RES_SURFACE];
                        r_out.interflow_flow <= r_store[RES_INTER];
                        r_out.ground_flow    <= r_store[RES_GROUND];
                        r_out.total_flow     <= r_tot;
                        r_out.unit_outflow   <= unit_flow;
                        r_store[RES_CHANNEL] <= unit_flow;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_op        = op;

    // An accepted item makes the block busy on the next cycle.
    `LRR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A rounded pervious depth never exceeds the raw depth.
    `LRR_ASSERT_IMPL(a_perv_fits, i_clk, i_rst_n, r_state == S_FLOW, i_acc[ACC_W-1:COEF_FRAC_BITS+DW] == '0)
    // A reservoir outflow never exceeds the larger of store and inflow.
    `LRR_ASSERT_IMPL(a_res_fits, i_clk, i_rst_n, r_state == S_RDONE, i_acc[ACC_W-1:COEF_FRAC_BITS+FW] == '0)
    // A result appears only from the final state of an item.
    `LRR_ASSERT_IMPL(a_out_load, i_clk, i_rst_n, $rose(r_out_vld), $past(r_state) == S_DONE)

endmodule

// ----- rtl/linear_reservoir_runoff_routing_unit.sv -----
// Linear reservoir runoff routing unit: one time step of a catchment unit
// per item. Takes an item only when idle and holds one finished result in an
// output register, so the next item may start while that result waits. With
// channel routing enabled, an item also runs the channel reservoir sum. The
// block is idle again from the edge that loads a result into the output
// register; a result still stalled when the next one is ready holds the
// sequencer in its last state until it is taken. The item rate is set by
// the single shared 32x32 multiply-accumulate unit, which forms every
// product in turn (depth scaling, depth-to-flow conversion and each
// reservoir sum chunk by chunk) and passes each through its product and
// accumulate registers before a step that depends on it goes on.
// Depends on lrr_pkg, lrr_cfg, lrr_mac and lrr_ctrl.
module linear_reservoir_runoff_routing_unit #(
    parameter int COEF_FRAC_BITS = lrr_pkg::COEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lrr_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lrr_pkg::t_out_item              o_out_data
);

    localparam int ACC_W = lrr_pkg::acc_width(COEF_FRAC_BITS);

    lrr_pkg::t_cfg      cfg;
    lrr_pkg::t_mac_op   mac_op;
    logic [ACC_W-1:0]   mac_acc;

    // Configuration registers.
    lrr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Sequencer with reservoir stores and output register.
    lrr_ctrl #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_op        (mac_op),
        .i_acc       (mac_acc)
    );

    // Shared multiply-accumulate unit.
    lrr_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (mac_acc)
    );

endmodule

// ----- verif/linear_reservoir_runoff_routing_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the linear reservoir runoff routing unit: it predicts the
// reservoir flows of every accepted depth transfer and compares them with each result.
// Depends on lrr_pkg and the unit's RTL.
module linear_reservoir_runoff_routing_unit_test;

    typedef logic [lrr_pkg::FLOW_WIDTH-1:0] t_flow;
    typedef logic [95:0] t_wide;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 60;
    localparam logic [lrr_pkg::CFG_IDX_W-1:0]  CFG_SPARE_IDX = lrr_pkg::CFG_IDX_W'(7);
    localparam logic [lrr_pkg::CFG_DATA_W-1:0] COEF_ONE      =
        lrr_pkg::CFG_DATA_W'(1) << lrr_pkg::COEF_FRAC_BITS;
    localparam logic [lrr_pkg::DEPTH_W-1:0]    DEPTH_MAX     = '1;
    localparam t_wide FLOW_CEILING = (t_wide'(1) << lrr_pkg::FLOW_WIDTH) - 1;
    localparam t_wide ROUND_HALF   = t_wide'(COEF_ONE) >> 1;

    // Register copy, reservoir stores and the flows still owed by the unit.
    class t_catchment_flows;
        lrr_pkg::t_cfg      regs;
        t_flow              surface_store;
        t_flow              interflow_store;
        t_flow              ground_store;
        t_flow              outlet_store;
        lrr_pkg::t_out_item expected_flows[$];
        int unsigned        mismatches;

        function new();
            regs            = '0;
            surface_store   = '0;
            interflow_store = '0;
            ground_store    = '0;
            outlet_store    = '0;
            mismatches      = 0;
        endfunction

        // Writes land masked to the register width; unknown indexes are dropped.
        function void set_register(logic [lrr_pkg::CFG_IDX_W-1:0] idx,
                                   logic [lrr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lrr_pkg::CFG_SURFACE_COEF:
                    regs.surface_coef     = data[lrr_pkg::COEF_REG_W-1:0];
                lrr_pkg::CFG_INTERFLOW_COEF:
                    regs.interflow_coef   = data[lrr_pkg::COEF_REG_W-1:0];
                lrr_pkg::CFG_GROUND_COEF:
                    regs.ground_coef      = data[lrr_pkg::COEF_REG_W-1:0];
                lrr_pkg::CFG_CHANNEL_COEF:
                    regs.channel_coef     = data[lrr_pkg::COEF_REG_W-1:0];
                lrr_pkg::CFG_IMPERV_FRAC:
                    regs.imperv_frac      = data[lrr_pkg::COEF_REG_W-1:0];
                lrr_pkg::CFG_UNIT_FACTOR:
                    regs.unit_factor      = data[lrr_pkg::FACTOR_W-1:0];
                lrr_pkg::CFG_CHANNEL_ROUTE:
                    regs.channel_route_en = data[0];
                default: ;
            endcase
        endfunction

        // Anything beyond one behaves as exactly one.
        function t_wide limit_one(logic [lrr_pkg::COEF_REG_W-1:0] c);
            return (t_wide'(c) > t_wide'(COEF_ONE)) ? t_wide'(COEF_ONE) : t_wide'(c);
        endfunction

        function t_flow saturate(t_wide v);
            return (v > FLOW_CEILING) ? t_flow'(FLOW_CEILING) : t_flow'(v);
        endfunction

        // First-order reservoir: c*q + (1-c)*x, rounded half up, no truncation inside.
        function t_flow recede(t_flow q, t_flow x, logic [lrr_pkg::COEF_REG_W-1:0] c);
            t_wide cw;
            t_wide kw;
            cw = limit_one(c);
            kw = t_wide'(COEF_ONE) - cw;
            return t_flow'((cw * t_wide'(q) + kw * t_wide'(x) + ROUND_HALF)
                           >> lrr_pkg::COEF_FRAC_BITS);
        endfunction

        function t_wide scale_pervious(logic [lrr_pkg::DEPTH_W-1:0] d, t_wide perv);
            return (t_wide'(d) * perv + ROUND_HALF) >> lrr_pkg::COEF_FRAC_BITS;
        endfunction

        function t_flow depth_to_flow(t_wide d);
            return saturate((d * t_wide'(regs.unit_factor)) >> lrr_pkg::FACTOR_FRAC_BITS);
        endfunction

        // One time step of the catchment unit for an accepted depth transfer.
        function void take_depths(lrr_pkg::t_in_item it);
            t_wide              perv;
            t_flow              in_s;
            t_flow              in_i;
            t_flow              in_g;
            t_flow              total;
            t_flow              outlet;
            lrr_pkg::t_out_item res;
            perv = t_wide'(COEF_ONE) - limit_one(regs.imperv_frac);
            in_s = depth_to_flow(scale_pervious(it.surface_depth, perv)
                                 + t_wide'(it.imperv_depth));
            in_i = depth_to_flow(scale_pervious(it.interflow_depth, perv));
            in_g = depth_to_flow(scale_pervious(it.ground_depth, perv));

            surface_store   = recede(surface_store, in_s, regs.surface_coef);
            interflow_store = recede(interflow_store, in_i, regs.interflow_coef);
            ground_store    = recede(ground_store, in_g, regs.ground_coef);

            total = saturate(t_wide'(surface_store) + t_wide'(interflow_store));
            total = saturate(t_wide'(total) + t_wide'(ground_store));

            // The outlet store follows the unit outflow whether routing is on or not.
            outlet = regs.channel_route_en ? recede(outlet_store, total, regs.channel_coef)
                                           : total;
            outlet_store = outlet;

            res.surface_flow   = surface_store;
            res.interflow_flow = interflow_store;
            res.ground_flow    = ground_store;
            res.total_flow     = total;
            res.unit_outflow   = outlet;
            expected_flows.push_back(res);
        endfunction

        function bit field_ok(string name, t_flow want, t_flow got);
            if (want === got) begin
                return 1'b1;
            end
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            return 1'b0;
        endfunction

        // Compares a result transfer against the oldest owed set of flows.
        function void compare_flows(lrr_pkg::t_out_item got);
            lrr_pkg::t_out_item want;
            bit                 ok;
            if (expected_flows.size() == 0) begin
                $display("%0t: result transfer with none owed, expected nothing, got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_flows.pop_front();
            ok = field_ok("surface_flow", want.surface_flow, got.surface_flow);
            ok = field_ok("interflow_flow", want.interflow_flow, got.interflow_flow) & ok;
            ok = field_ok("ground_flow", want.ground_flow, got.ground_flow) & ok;
            ok = field_ok("total_flow", want.total_flow, got.total_flow) & ok;
            ok = field_ok("unit_outflow", want.unit_outflow, got.unit_outflow) & ok;
            if (!ok) begin
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_flows.size();
        endfunction
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic [lrr_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [lrr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    lrr_pkg::t_in_item              in_data  = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    lrr_pkg::t_out_item             out_data;

    t_catchment_flows flows;
    int unsigned      sender_idle_pct = 0;
    int unsigned      stall_pct       = 0;
    int unsigned      cycle_count     = 0;

    linear_reservoir_runoff_routing_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog, result checking and random back-pressure on the result side.
    always @(posedge clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
            if (rst_n && out_valid && !out_stall) begin
                flows.compare_flows(out_data);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(logic [lrr_pkg::CFG_IDX_W-1:0] idx,
                             logic [lrr_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        flows.set_register(idx, data);
    endtask

    // Writes every register, then an unused index that must change nothing.
    task automatic program_regs(logic [lrr_pkg::CFG_DATA_W-1:0] surf,
                                logic [lrr_pkg::CFG_DATA_W-1:0] inter,
                                logic [lrr_pkg::CFG_DATA_W-1:0] grnd,
                                logic [lrr_pkg::CFG_DATA_W-1:0] chan,
                                logic [lrr_pkg::CFG_DATA_W-1:0] imperv,
                                logic [lrr_pkg::CFG_DATA_W-1:0] factor,
                                logic [lrr_pkg::CFG_DATA_W-1:0] route);
        write_reg(lrr_pkg::CFG_SURFACE_COEF, surf);
        write_reg(lrr_pkg::CFG_INTERFLOW_COEF, inter);
        write_reg(lrr_pkg::CFG_GROUND_COEF, grnd);
        write_reg(lrr_pkg::CFG_CHANNEL_COEF, chan);
        write_reg(lrr_pkg::CFG_IMPERV_FRAC, imperv);
        write_reg(lrr_pkg::CFG_UNIT_FACTOR, factor);
        write_reg(lrr_pkg::CFG_CHANNEL_ROUTE, route);
        write_reg(CFG_SPARE_IDX, $urandom());
        cfg_we <= 1'b0;
    endtask

    // Offers one depth transfer, with random gaps beforehand, and waits for acceptance.
    task automatic send_depths(lrr_pkg::t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        flows.take_depths(it);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flows.pending() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [lrr_pkg::DEPTH_W-1:0] pick_depth();
        case ($urandom_range(7))
            0:       return '0;
            1:       return DEPTH_MAX;
            default: return lrr_pkg::DEPTH_W'($urandom());
        endcase
    endfunction

    // Coefficients: the ends of the range, values above one and raw 32-bit words.
    function automatic logic [lrr_pkg::CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COEF_ONE;
            2:       return $urandom();
            3:       return COEF_ONE + $urandom_range(1, COEF_ONE - 1);
            default: return $urandom_range(COEF_ONE);
        endcase
    endfunction

    function automatic logic [lrr_pkg::CFG_DATA_W-1:0] pick_factor();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        flows = new();
        sender_idle_pct = 20;
        stall_pct       = 46;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Typical coefficients with routing: extremes and bit patterns of each depth.
        program_regs(32'h0000_C000, 32'h0000_F000, 32'h0000_FF00, 32'h0000_8000,
                     32'h0000_1000, 32'h0100_0000, 32'h0000_0001);
        send_depths('0);
        send_depths('1);
        send_depths({DEPTH_MAX, 20'h0, 20'h0, 20'h0});
        send_depths({20'h0, DEPTH_MAX, 20'h0, 20'h0});
        send_depths({20'h0, 20'h0, DEPTH_MAX, 20'h0});
        send_depths({20'h0, 20'h0, 20'h0, DEPTH_MAX});
        send_depths({20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h55555});
        send_depths({20'h55555, 20'hAAAAA, 20'h55555, 20'hAAAAA});
        send_depths('0);
        hold_until_drained();

        // Coefficients of one and above hold the stores; whole area impervious;
        // largest factor; routing off.
        program_regs(COEF_ONE, 32'h0001_FFFF, 32'hFFFF_FFFF, COEF_ONE,
                     COEF_ONE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_depths('1);
        send_depths({DEPTH_MAX, 20'h0, 20'h0, 20'h0});
        send_depths({20'h0, 20'h0, 20'h0, DEPTH_MAX});
        hold_until_drained();

        // Zero coefficients pass the inflow straight through; the fraction sits above
        // one; the route enable is written with its low bit clear.
        program_regs('0, '0, '0, '0, 32'h0001_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_depths('1);
        send_depths({20'h0, 20'h0, 20'h0, DEPTH_MAX});
        send_depths({DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 20'h0});
        hold_until_drained();

        // Half fraction and unit factor of one, so rounding half up shows on small depths.
        program_regs(32'hFFFE_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                     32'h0000_8000, 32'h0001_0000, 32'h0000_0001);
        send_depths({20'h1, 20'h1, 20'h1, 20'h0});
        send_depths({20'h3, 20'h1, 20'h0, 20'h1});
        send_depths({20'h0, 20'h0, 20'h0, 20'h0});

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            hold_until_drained();
            if (ph == 4) begin
                sender_idle_pct = 46;
                stall_pct       = 20;
            end else if (ph == 7) begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            program_regs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                         pick_coef(), pick_factor(), $urandom());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(59) == 0) begin
                    hold_until_drained();
                end
                send_depths({pick_depth(), pick_depth(), pick_depth(), pick_depth()});
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (flows.mismatches == 0 && flows.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
